// ===== src/mbrtu_pkg.sv =====
// Shared constants, codes and the CRC-16/Modbus byte fold for the Modbus RTU master
package mbrtu_pkg;

	// default depth of the response byte counter
	localparam int RX_BUFFER_DEPTH_DEF = 32;

	// input word kinds
	localparam logic [1:0] KIND_START_READ  = 2'd0;
	localparam logic [1:0] KIND_START_WRITE = 2'd1;
	localparam logic [1:0] KIND_RX_BYTE     = 2'd2;
	localparam logic [1:0] KIND_TIMEOUT     = 2'd3;

	// transaction in flight
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	// transaction status codes
	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_NONE      = 4'd1,
		ST_CRC       = 4'd2,
		ST_EXCEPTION = 4'd3,
		ST_ADDR      = 4'd4,
		ST_FUNC      = 4'd5,
		ST_LENGTH    = 4'd6,
		ST_COUNT     = 4'd7,
		ST_ECHO      = 4'd8
	} status_t;

	// protocol bytes and CRC constants
	localparam logic [7:0]  FUNC_READ      = 8'h03;
	localparam logic [7:0]  FUNC_WRITE     = 8'h06;
	localparam logic [7:0]  READ_QTY_HI    = 8'h00;
	localparam logic [7:0]  READ_QTY_LO    = 8'h01;
	localparam logic [7:0]  READ_BYTE_CNT  = 8'h02;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;

	// request and response frame layout
	localparam int          REQ_LEN        = 8;
	localparam int          REQ_BODY_LEN   = 6;
	localparam int          READ_RSP_LEN   = 7;
	localparam int          EXC_MIN_LEN    = 5;
	localparam int          MIN_LEN        = 3;
	localparam logic [2:0]  TX_LAST_IDX    = 3'd7;
	localparam logic [2:0]  TX_CRC_LO_IDX  = 3'd6;
	localparam logic [2:0]  TX_FOLD_LAST   = 3'd4;

	// one byte through the reflected CRC-16/Modbus
	function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== src/modbus_rtu_register_transaction.sv =====
// Modbus RTU single register master: request framing, response capture and checking
//
//  channel | handshake          | word
//  --------+--------------------+---------------------------------------------------
//  in      | in_valid/in_stall  | kind, slave_id, reg_address, write_value, rx_byte, frame_end
//  out     | out_valid/out_stall| out_kind, tx_byte, tx_last, status, read_value,
//          |                    | exception_code, rx_length
//
// An input word is taken into an input register, then handled in one pass into the
// output register. Received bytes and timeouts go at one word per cycle while out_stall
// lets the output drain; a start word holds the input for the eight request bytes it sends,
// one per cycle unless out_stall holds them, while the request CRC is folded one byte per
// sent word. arst_n clears all control state at once, no clearing pass. out_stall holds
// the output word and backs up into in_stall through the input register.
module modbus_rtu_register_transaction #(
	parameter int RX_BUFFER_DEPTH = mbrtu_pkg::RX_BUFFER_DEPTH_DEF,
	localparam int CNT_W = $clog2(RX_BUFFER_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	// input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       kind,
	input  logic [7:0]       slave_id,
	input  logic [15:0]      reg_address,
	input  logic [15:0]      write_value,
	input  logic [7:0]       rx_byte,
	input  logic             frame_end,
	// output channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic             out_kind,
	output logic [7:0]       tx_byte,
	output logic             tx_last,
	output logic [3:0]       status,
	output logic [15:0]      read_value,
	output logic [7:0]       exception_code,
	output logic [CNT_W-1:0] rx_length
);

	// input register
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  slave_s1;
	logic [15:0] addr_s1;
	logic [15:0] wval_s1;
	logic [7:0]  rxb_s1;
	logic        fend_s1;

	// transaction state
	mbrtu_pkg::op_t   pending_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      rx_crc_q;
	logic [7:0]       told_q;
	logic [7:0]       tnew_q;
	logic [7:0]       resp_q [8];
	logic [7:0]       req_q [6];
	logic [15:0]      crc_tx_q;

	// output register
	logic             out_valid_q;
	logic             out_stat_q;
	logic [2:0]       idx_q;
	logic [3:0]       status_q;
	logic [15:0]      value_q;
	logic [7:0]       exc_q;
	logic [CNT_W-1:0] len_q;

	// next state of the receive side
	logic [CNT_W-1:0] cnt_n;
	logic [15:0]      crc_n;
	logic [7:0]       told_n;
	logic [7:0]       tnew_n;
	logic [7:0]       resp_n [8];

	mbrtu_pkg::status_t st_n;
	logic [15:0]        value_n;
	logic [7:0]         exc_n;

	logic out_free;
	logic step;
	logic is_start;
	logic start_evt;
	logic rx_evt;
	logic close_evt;
	logic out_take;
	logic [2:0] fold_idx;

	// handshake between stages
	assign out_take  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || (out_take && (out_stat_q || idx_q == mbrtu_pkg::TX_LAST_IDX));
	assign in_stall  = valid_s1 && !out_free;
	assign step      = valid_s1 && out_free;
	assign is_start  = (kind_s1 == mbrtu_pkg::KIND_START_READ) ||
	                   (kind_s1 == mbrtu_pkg::KIND_START_WRITE);
	assign start_evt = step && is_start;
	assign rx_evt    = step && (pending_q != mbrtu_pkg::OP_NONE) &&
	                   (kind_s1 == mbrtu_pkg::KIND_RX_BYTE);
	assign close_evt = step && (pending_q != mbrtu_pkg::OP_NONE) &&
	                   ((kind_s1 == mbrtu_pkg::KIND_TIMEOUT) ||
	                    (kind_s1 == mbrtu_pkg::KIND_RX_BYTE && fend_s1));
	assign fold_idx  = idx_q + 3'd1;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (!in_stall) begin
			kind_s1  <= kind;
			slave_s1 <= slave_id;
			addr_s1  <= reg_address;
			wval_s1  <= write_value;
			rxb_s1   <= rx_byte;
			fend_s1  <= frame_end;
		end
	end

	// append the received byte; the last two bytes stay out of the running crc
	always_comb begin
		cnt_n  = cnt_q;
		crc_n  = rx_crc_q;
		told_n = told_q;
		tnew_n = tnew_q;
		resp_n = resp_q;
		if (kind_s1 == mbrtu_pkg::KIND_RX_BYTE && cnt_q < CNT_W'(RX_BUFFER_DEPTH)) begin
			if (cnt_q < CNT_W'(mbrtu_pkg::REQ_LEN)) begin
				resp_n[cnt_q[2:0]] = rxb_s1;
			end
			if (cnt_q >= CNT_W'(2)) begin
				crc_n = mbrtu_pkg::crc_fold(rx_crc_q, told_q);
			end
			told_n = tnew_q;
			tnew_n = rxb_s1;
			cnt_n  = cnt_q + CNT_W'(1);
		end
	end

	// response checks in priority order
	always_comb begin
		st_n    = mbrtu_pkg::ST_OK;
		value_n = 16'h0000;
		exc_n   = 8'h00;
		if (cnt_n == '0) begin
			st_n = mbrtu_pkg::ST_NONE;
		end else if (cnt_n < CNT_W'(mbrtu_pkg::MIN_LEN) || {tnew_n, told_n} != crc_n) begin
			st_n = mbrtu_pkg::ST_CRC;
		end else if (cnt_n >= CNT_W'(mbrtu_pkg::EXC_MIN_LEN) && resp_n[1][7]) begin
			st_n  = mbrtu_pkg::ST_EXCEPTION;
			exc_n = resp_n[2];
		end else if (pending_q == mbrtu_pkg::OP_READ) begin
			if (resp_n[0] != req_q[0]) begin
				st_n = mbrtu_pkg::ST_ADDR;
			end else if (resp_n[1] != mbrtu_pkg::FUNC_READ) begin
				st_n = mbrtu_pkg::ST_FUNC;
			end else if (cnt_n != CNT_W'(mbrtu_pkg::READ_RSP_LEN)) begin
				st_n = mbrtu_pkg::ST_LENGTH;
			end else if (resp_n[2] != mbrtu_pkg::READ_BYTE_CNT) begin
				st_n = mbrtu_pkg::ST_COUNT;
			end else begin
				value_n = {resp_n[3], resp_n[4]};
			end
		end else if (cnt_n != CNT_W'(mbrtu_pkg::REQ_LEN)) begin
			st_n = mbrtu_pkg::ST_LENGTH;
		end else if (resp_n[0] != req_q[0] || resp_n[1] != req_q[1] ||
		             resp_n[2] != req_q[2] || resp_n[3] != req_q[3] ||
		             resp_n[4] != req_q[4] || resp_n[5] != req_q[5] ||
		             resp_n[6] != crc_tx_q[7:0] || resp_n[7] != crc_tx_q[15:8]) begin
			st_n = mbrtu_pkg::ST_ECHO;
		end
	end

	// transaction control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= mbrtu_pkg::OP_NONE;
			cnt_q     <= '0;
			rx_crc_q  <= mbrtu_pkg::CRC_INIT;
			told_q    <= 8'h00;
			tnew_q    <= 8'h00;
		end else if (start_evt) begin
			pending_q <= (kind_s1 == mbrtu_pkg::KIND_START_READ) ? mbrtu_pkg::OP_READ
			                                                     : mbrtu_pkg::OP_WRITE;
			cnt_q     <= '0;
			rx_crc_q  <= mbrtu_pkg::CRC_INIT;
			told_q    <= 8'h00;
			tnew_q    <= 8'h00;
		end else begin
			if (rx_evt) begin
				cnt_q    <= cnt_n;
				rx_crc_q <= crc_n;
				told_q   <= told_n;
				tnew_q   <= tnew_n;
			end
			if (close_evt) begin
				pending_q <= mbrtu_pkg::OP_NONE;
			end
		end
	end

	// request and response byte stores, request crc folded as bytes go out
	always_ff @(posedge clk) begin
		if (rx_evt) begin
			resp_q <= resp_n;
		end
		if (start_evt) begin
			req_q[0] <= slave_s1;
			req_q[1] <= (kind_s1 == mbrtu_pkg::KIND_START_READ) ? mbrtu_pkg::FUNC_READ
			                                                    : mbrtu_pkg::FUNC_WRITE;
			req_q[2] <= addr_s1[15:8];
			req_q[3] <= addr_s1[7:0];
			req_q[4] <= (kind_s1 == mbrtu_pkg::KIND_START_READ) ? mbrtu_pkg::READ_QTY_HI
			                                                    : wval_s1[15:8];
			req_q[5] <= (kind_s1 == mbrtu_pkg::KIND_START_READ) ? mbrtu_pkg::READ_QTY_LO
			                                                    : wval_s1[7:0];
			crc_tx_q <= mbrtu_pkg::crc_fold(mbrtu_pkg::CRC_INIT, slave_s1);
		end else if (out_take && !out_stat_q && idx_q <= mbrtu_pkg::TX_FOLD_LAST) begin
			crc_tx_q <= mbrtu_pkg::crc_fold(crc_tx_q, req_q[fold_idx]);
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_stat_q  <= 1'b0;
			idx_q       <= 3'd0;
		end else begin
			if (out_take) begin
				if (out_stat_q || idx_q == mbrtu_pkg::TX_LAST_IDX) begin
					out_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
			if (start_evt) begin
				out_valid_q <= 1'b1;
				out_stat_q  <= 1'b0;
				idx_q       <= 3'd0;
			end else if (close_evt) begin
				out_valid_q <= 1'b1;
				out_stat_q  <= 1'b1;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (start_evt) begin
			status_q <= mbrtu_pkg::ST_OK;
			value_q  <= 16'h0000;
			exc_q    <= 8'h00;
			len_q    <= '0;
		end else if (close_evt) begin
			status_q <= st_n;
			value_q  <= value_n;
			exc_q    <= exc_n;
			len_q    <= cnt_n;
		end
	end

	// request byte select
	always_comb begin
		case (idx_q)
			3'd0:    tx_byte = req_q[0];
			3'd1:    tx_byte = req_q[1];
			3'd2:    tx_byte = req_q[2];
			3'd3:    tx_byte = req_q[3];
			3'd4:    tx_byte = req_q[4];
			3'd5:    tx_byte = req_q[5];
			3'd6:    tx_byte = crc_tx_q[7:0];
			default: tx_byte = crc_tx_q[15:8];
		endcase
		if (out_stat_q) begin
			tx_byte = 8'h00;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_kind       = out_stat_q;
	assign tx_last        = !out_stat_q && idx_q == mbrtu_pkg::TX_LAST_IDX;
	assign status         = status_q;
	assign read_value     = value_q;
	assign exception_code = exc_q;
	assign rx_length      = len_q;

`ifndef NO_ASSERTIONS
	// a start word always opens a request at its first byte
	a_start_opens_tx: assert property (@(posedge clk) disable iff (!arst_n)
		start_evt |=> (out_valid_q && !out_stat_q && idx_q == 3'd0))
		else $error("start word did not open a request");

	// the kept byte count never passes the buffer depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(RX_BUFFER_DEPTH))
		else $error("receive count beyond buffer depth");

	// a closed transaction leaves no pending operation
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(close_evt && !start_evt) |=> (pending_q == mbrtu_pkg::OP_NONE))
		else $error("transaction still pending after status");

	// a status word carries no request byte and a code in range
	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stat_q) |-> (tx_byte == 8'h00 && !tx_last &&
		 status_q <= mbrtu_pkg::ST_ECHO))
		else $error("malformed status word");
`endif

endmodule
